>>> design/mi4_pkg.sv
// Shared types and constants for the 4x4 matrix inverse core.
// No dependencies; imported by the core, the multiplier and the divider.
`timescale 1ns / 1ps
`default_nettype none

package mi4_pkg;

    // Sequencer states of the core
    typedef enum logic [3:0] {
        S_LOAD,
        S_COF_RD,
        S_COF_OP,
        S_COF_MUL,
        S_COF_WR,
        S_DET_RD,
        S_DET_OP,
        S_DET_MUL,
        S_DIV_RD,
        S_DIV_OP,
        S_DIV_RUN,
        S_DIV_OUT
    } t_state;

    // Result of one Q48.16 fixed-point multiply
    typedef struct packed {
        logic               sat;
        logic signed [63:0] value;
    } t_mul_res;

    // Result of one Q16.16 quotient
    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } t_div_res;

    localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

endpackage

`default_nettype wire

>>> design/matrix_inverse_4x4_core.sv
// Streaming matrix inverse by adjugate and cofactors, Q16.16 in and out.
// Loads MATRIX_DIM^2 items at one per cycle, then computes with stall high.
// Each multiply-accumulate reads memory, then runs in mi4_mul; 4x4 takes 144
// cofactor ops, 16 writes and 4 determinant ops before the first result.
// Each result is then divided by the bit-serial mi4_div.
// Reset (synchronous, active low) clears the sequencer, load count, output valid and determinant.
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_4x4_core import mi4_pkg::*; #(
    parameter int MATRIX_DIM = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_element_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_inverse_value,
    output logic [1:0]         o_out_row,
    output logic [1:0]         o_out_col,
    output logic signed [31:0] o_det_value,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last
);

    localparam int MD    = MATRIX_DIM;
    localparam int CELLS = MD * MD;
    localparam int AW    = $clog2(CELLS);
    localparam int MSZ   = MD - 1;
    localparam logic [1:0] LASTIDX   = 2'(MD - 1);
    localparam logic [1:0] J_FIRST   = (MSZ == 3) ? 2'd0 : 2'd2;
    localparam logic [1:0] I0        = (MSZ == 3) ? 2'd1 : 2'd0;
    localparam logic [3:0] LOAD_LAST = 4'(CELLS - 1);

    // Row-major address of (row, col)
    function automatic logic [AW-1:0] f_addr(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] a;
        a = 4'(row) * 4'(MD) + 4'(col);
        return a[AW-1:0];
    endfunction

    // Index i of a list with entry p removed
    function automatic logic [1:0] f_skip(input logic [1:0] i, input logic [1:0] p);
        return (i < p) ? i : i + 2'd1;
    endfunction

    // Address of minor element (i, k) with row pr and column pc removed
    function automatic logic [AW-1:0] f_sub(input logic [1:0] i, input logic [1:0] k,
                                            input logic [1:0] pr, input logic [1:0] pc);
        return f_addr(f_skip(i, pr), f_skip(k, pc));
    endfunction

    // Saturating add, returns {sat, sum}
    function automatic logic [64:0] f_sat_add(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? MIN64 : MAX64)};
        end
        return {1'b0, s[63:0]};
    endfunction

    // Saturating negate, returns {sat, value}
    function automatic logic [64:0] f_sat_neg(input logic signed [63:0] a);
        if (a == MIN64) begin
            return {1'b1, MAX64};
        end
        return {1'b0, -a};
    endfunction

    t_state r_state;
    t_state n_state;

    // Memories
    logic signed [31:0] r_mat [CELLS];
    logic [64:0]        r_adj [CELLS];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;
    logic [64:0]        r_rd_adj;

    // Sequencer registers
    logic [3:0]         r_load_cnt;
    logic [1:0]         r_cr;
    logic [1:0]         r_cc;
    logic [1:0]         r_j;
    logic               r_t;
    logic               r_outer;
    logic signed [63:0] r_acc2;
    logic signed [63:0] r_acc3;
    logic signed [63:0] r_res;
    logic               r_cof_sat;
    logic signed [63:0] r_det;
    logic               r_det_sat;
    logic signed [31:0] r_q;
    logic               r_qs;

    // Output register
    logic               r_ov;
    logic signed [31:0] r_o_inv;
    logic [1:0]         r_o_row;
    logic [1:0]         r_o_col;
    logic signed [31:0] r_o_det;
    logic               r_o_sing;
    logic               r_o_sat;
    logic               r_o_last;

    // Control from the output decoder
    logic               w_mat_we;
    logic [AW-1:0]      w_ra_a;
    logic [AW-1:0]      w_ra_b;
    logic               w_adj_we;
    logic [AW-1:0]      w_adj_wa;
    logic [AW-1:0]      w_adj_ra;
    logic               w_mul_start;
    logic signed [63:0] w_mul_y;
    logic               w_div_start;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_mul_done;
    t_mul_res           w_mul_res;
    logic               w_div_done;
    t_div_res           w_div_res;
    logic [64:0]        w_neg_acc2;
    logic signed [63:0] w_elem_b;
    logic signed [63:0] w_ycof;
    logic               w_ysat;
    logic signed [63:0] w_add_a;
    logic [64:0]        w_add;
    logic [64:0]        w_neg_res;
    logic               w_odd;
    logic [64:0]        w_adj_wd;
    logic               w_det32_sat;
    logic signed [31:0] w_det32;
    logic               w_det_sat_all;
    logic               w_det_zero;
    logic               w_cof_last;
    logic               w_out_last;

    assign o_in_stall = (r_state != S_LOAD);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;

    // Cofactor multiply operand: element or inner minor, with checkerboard sign
    assign w_neg_acc2 = f_sat_neg(r_acc2);
    assign w_elem_b   = 64'(r_rd_b);
    assign w_ycof = r_outer ? (r_j[0] ? signed'(w_neg_acc2[63:0]) : r_acc2)
                            : (r_t ? -w_elem_b : w_elem_b);
    assign w_ysat = r_outer && r_j[0] && w_neg_acc2[64];

    // Accumulate into the minor, the outer sum or the determinant
    assign w_add_a = (r_state == S_DET_MUL) ? r_det : (r_outer ? r_acc3 : r_acc2);
    assign w_add   = f_sat_add(w_add_a, w_mul_res.value);

    // Cofactor sign and adjugate write word
    assign w_neg_res = f_sat_neg(r_res);
    assign w_odd     = r_cr[0] ^ r_cc[0];
    assign w_adj_wd  = w_odd ? {r_cof_sat | w_neg_res[64], w_neg_res[63:0]}
                             : {r_cof_sat, r_res};

    // Determinant clipped to 32 bits
    assign w_det32_sat   = !((&r_det[63:31]) || !(|r_det[63:31]));
    assign w_det32       = w_det32_sat ? (r_det[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                       : signed'(r_det[31:0]);
    assign w_det_sat_all = r_det_sat | w_det32_sat;
    assign w_det_zero    = (r_det == 64'sd0);

    assign w_cof_last = (r_cr == LASTIDX) && (r_cc == LASTIDX);
    assign w_out_last = w_cof_last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && r_load_cnt == LOAD_LAST) begin
                    n_state = S_COF_RD;
                end
            end
            S_COF_RD: n_state = S_COF_OP;
            S_COF_OP: n_state = (MSZ == 1) ? S_COF_WR : S_COF_MUL;
            S_COF_MUL: begin
                if (w_mul_done) begin
                    if (!r_outer) begin
                        n_state = (r_t && MSZ == 2) ? S_COF_WR : S_COF_RD;
                    end else begin
                        n_state = (r_j == 2'd2) ? S_COF_WR : S_COF_RD;
                    end
                end
            end
            S_COF_WR: n_state = w_cof_last ? S_DET_RD : S_COF_RD;
            S_DET_RD: n_state = S_DET_OP;
            S_DET_OP: n_state = S_DET_MUL;
            S_DET_MUL: begin
                if (w_mul_done) begin
                    n_state = (r_j == LASTIDX) ? S_DIV_RD : S_DET_RD;
                end
            end
            S_DIV_RD: n_state = S_DIV_OP;
            S_DIV_OP: n_state = w_det_zero ? S_DIV_OUT : S_DIV_RUN;
            S_DIV_RUN: begin
                if (w_div_done) begin
                    n_state = S_DIV_OUT;
                end
            end
            S_DIV_OUT: begin
                if (w_out_free) begin
                    n_state = w_out_last ? S_LOAD : S_DIV_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Output decode: memory addresses, enables and unit starts
    always_comb begin
        w_mat_we    = 1'b0;
        w_ra_a      = '0;
        w_ra_b      = '0;
        w_adj_we    = 1'b0;
        w_adj_wa    = f_addr(r_cc, r_cr);
        w_adj_ra    = '0;
        w_mul_start = 1'b0;
        w_mul_y     = w_ycof;
        w_div_start = 1'b0;
        case (r_state)
            S_LOAD: w_mat_we = w_in_acc;
            S_COF_RD: begin
                if (MSZ == 1) begin
                    w_ra_a = f_sub(2'd0, 2'd0, r_cr, r_cc);
                end else if (r_outer) begin
                    w_ra_a = f_sub(2'd0, r_j, r_cr, r_cc);
                end else begin
                    w_ra_a = f_sub(I0, f_skip({1'b0, r_t}, r_j), r_cr, r_cc);
                    w_ra_b = f_sub(I0 + 2'd1, f_skip({1'b0, ~r_t}, r_j), r_cr, r_cc);
                end
            end
            S_COF_OP: w_mul_start = (MSZ != 1);
            S_COF_WR: w_adj_we = 1'b1;
            S_DET_RD: begin
                w_ra_a   = f_addr(2'd0, r_j);
                w_adj_ra = f_addr(r_j, 2'd0);
            end
            S_DET_OP: begin
                w_mul_start = 1'b1;
                w_mul_y     = signed'(r_rd_adj[63:0]);
            end
            S_DIV_RD: w_adj_ra = f_addr(r_cr, r_cc);
            S_DIV_OP: w_div_start = !w_det_zero;
            default: begin
            end
        endcase
    end

    // Matrix memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_mat_we) begin
            r_mat[r_load_cnt[AW-1:0]] <= i_element_value;
        end
        r_rd_a <= r_mat[w_ra_a];
        r_rd_b <= r_mat[w_ra_b];
    end

    // Adjugate memory: sat flag above the Q48.16 value; written before any read
    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            r_adj[w_adj_wa] <= w_adj_wd;
        end
        r_rd_adj <= r_adj[w_adj_ra];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= 4'd0;
            r_ov       <= 1'b0;
            r_det      <= 64'sd0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_load_cnt <= (r_load_cnt == LOAD_LAST) ? 4'd0 : r_load_cnt + 4'd1;
            end
            if (r_state == S_DIV_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_COF_WR && w_cof_last) begin
                r_det <= 64'sd0;
            end else if (r_state == S_DET_MUL && w_mul_done) begin
                r_det <= signed'(w_add[63:0]);
            end
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && r_load_cnt == LOAD_LAST) begin
                    r_cr      <= 2'd0;
                    r_cc      <= 2'd0;
                    r_acc2    <= 64'sd0;
                    r_acc3    <= 64'sd0;
                    r_j       <= J_FIRST;
                    r_t       <= 1'b0;
                    r_outer   <= 1'b0;
                    r_cof_sat <= 1'b0;
                end
            end
            S_COF_OP: begin
                r_cof_sat <= r_cof_sat | w_ysat;
                if (MSZ == 1) begin
                    r_res <= 64'(r_rd_a);
                end
            end
            S_COF_MUL: begin
                if (w_mul_done) begin
                    r_cof_sat <= r_cof_sat | w_add[64] | w_mul_res.sat;
                    if (!r_outer) begin
                        r_acc2 <= signed'(w_add[63:0]);
                        if (!r_t) begin
                            r_t <= 1'b1;
                        end else begin
                            r_t <= 1'b0;
                            if (MSZ == 3) begin
                                r_outer <= 1'b1;
                            end else begin
                                r_res <= signed'(w_add[63:0]);
                            end
                        end
                    end else begin
                        r_acc3  <= signed'(w_add[63:0]);
                        r_acc2  <= 64'sd0;
                        r_outer <= 1'b0;
                        if (r_j == 2'd2) begin
                            r_res <= signed'(w_add[63:0]);
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
            end
            S_COF_WR: begin
                // Advance to the next cofactor and clear its accumulators
                r_acc2    <= 64'sd0;
                r_acc3    <= 64'sd0;
                r_j       <= J_FIRST;
                r_t       <= 1'b0;
                r_outer   <= 1'b0;
                r_cof_sat <= 1'b0;
                if (w_cof_last) begin
                    r_cr      <= 2'd0;
                    r_cc      <= 2'd0;
                    r_j       <= 2'd0;
                    r_det_sat <= 1'b0;
                end else if (r_cc == LASTIDX) begin
                    r_cc <= 2'd0;
                    r_cr <= r_cr + 2'd1;
                end else begin
                    r_cc <= r_cc + 2'd1;
                end
            end
            S_DET_OP: r_det_sat <= r_det_sat | r_rd_adj[64];
            S_DET_MUL: begin
                if (w_mul_done) begin
                    r_det_sat <= r_det_sat | w_add[64] | w_mul_res.sat;
                    if (r_j == LASTIDX) begin
                        r_cr <= 2'd0;
                        r_cc <= 2'd0;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            S_DIV_OP: begin
                if (w_det_zero) begin
                    r_q  <= 32'sd0;
                    r_qs <= w_det_sat_all;
                end else begin
                    r_qs <= w_det_sat_all | r_rd_adj[64];
                end
            end
            S_DIV_RUN: begin
                if (w_div_done) begin
                    r_q  <= w_div_res.value;
                    r_qs <= r_qs | w_div_res.sat;
                end
            end
            S_DIV_OUT: begin
                if (w_out_free) begin
                    r_o_inv  <= r_q;
                    r_o_row  <= r_cr;
                    r_o_col  <= r_cc;
                    r_o_det  <= w_det32;
                    r_o_sing <= w_det_zero;
                    r_o_sat  <= r_qs;
                    r_o_last <= w_out_last;
                    if (r_cc == LASTIDX) begin
                        r_cc <= 2'd0;
                        r_cr <= r_cr + 2'd1;
                    end else begin
                        r_cc <= r_cc + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    mi4_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (r_rd_a),
        .i_y     (w_mul_y),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    mi4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (signed'(r_rd_adj[63:0])),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    assign o_out_valid     = r_ov;
    assign o_inverse_value = r_o_inv;
    assign o_out_row       = r_o_row;
    assign o_out_col       = r_o_col;
    assign o_det_value     = r_o_det;
    assign o_singular      = r_o_sing;
    assign o_saturated     = r_o_sat;
    assign o_last          = r_o_last;

endmodule

`default_nettype wire

>>> design/mi4_mul.sv
// Multi-cycle Q48.16 multiplier: 32-bit element times 64-bit value.
// Two 32x32 partial products on one shared multiplier, then round and saturate.
// Depends on mi4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mi4_mul import mi4_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_x,
    input  logic signed [63:0] i_y,
    output logic               o_done,
    output t_mul_res           o_res
);

    logic [1:0]  r_ph;
    logic [31:0] r_xm;
    logic [63:0] r_ym;
    logic        r_neg;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic        r_done;
    t_mul_res    r_res;
    t_mul_res    n_res;
    logic [63:0] w_prod;
    logic [96:0] w_sum;
    logic        w_ovf;
    logic [63:0] w_mag;

    // Share one 32x32 multiplier between the low and high halves
    assign w_prod = r_xm * ((r_ph == 2'd1) ? r_ym[31:0] : r_ym[63:32]);

    // Combine halves, add rounding half-LSB, drop 16 fraction bits
    assign w_sum = {1'b0, r_phi, 32'b0} + {33'b0, r_plo} + 97'h8000;
    assign w_ovf = |w_sum[96:80];
    assign w_mag = w_sum[79:16];

    // Apply the sign and clip to the signed 64-bit range
    always_comb begin
        n_res.sat   = 1'b0;
        n_res.value = signed'(w_mag);
        if (w_ovf) begin
            n_res.sat   = 1'b1;
            n_res.value = r_neg ? MIN64 : MAX64;
        end else if (!r_neg) begin
            if (w_mag[63]) begin
                n_res.sat   = 1'b1;
                n_res.value = MAX64;
            end
        end else begin
            if (w_mag > 64'h8000_0000_0000_0000) begin
                n_res.sat   = 1'b1;
                n_res.value = MIN64;
            end else begin
                n_res.value = signed'(64'd0 - w_mag);
            end
        end
    end

    // Step through latch, low half, high half, normalize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                2'd0: begin
                    if (i_start) begin
                        r_ph <= 2'd1;
                    end
                end
                2'd1: r_ph <= 2'd2;
                2'd2: r_ph <= 2'd3;
                default: begin
                    r_ph   <= 2'd0;
                    r_done <= 1'b1;
                end
            endcase
        end
    end

    // Hold operands and partial products
    always_ff @(posedge i_clk) begin
        if (r_ph == 2'd0 && i_start) begin
            r_xm  <= i_x[31] ? (32'd0 - i_x) : i_x;
            r_ym  <= i_y[63] ? (64'd0 - i_y) : i_y;
            r_neg <= i_x[31] ^ i_y[63];
        end
        if (r_ph == 2'd1) begin
            r_plo <= w_prod;
        end
        if (r_ph == 2'd2) begin
            r_phi <= w_prod;
        end
        if (r_ph == 2'd3) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> design/mi4_div.sv
// Bit-serial divider: round(num * 2^16 / den), saturated to 32 bits.
// One quotient bit per cycle after a single overflow compare. Depends on mi4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mi4_div import mi4_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output t_div_res           o_res
);

    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rem;
    logic [31:0] r_nb;
    logic [31:0] r_q;
    logic [63:0] r_dd;
    logic        r_neg;
    t_div_res    r_res;
    logic [63:0] w_mn;
    logic [63:0] w_dd;
    logic        w_neg;
    logic        w_ovf;
    logic [64:0] w_rem2;
    logic        w_ge;
    logic        w_rnd;
    logic [32:0] w_qr;
    logic [32:0] w_lim;
    logic        w_sat;
    logic [32:0] w_val;
    logic [32:0] w_out;

    assign w_mn  = i_num[63] ? (64'd0 - i_num) : i_num;
    assign w_dd  = i_den[63] ? (64'd0 - i_den) : i_den;
    assign w_neg = i_num[63] ^ i_den[63];
    // Quotient reaches 2^32 when the upper part already holds the divisor
    assign w_ovf = {16'b0, w_mn[63:16]} >= w_dd;

    // One restoring step
    assign w_rem2 = {r_rem, r_nb[31]};
    assign w_ge   = w_rem2 >= {1'b0, r_dd};

    // Round to nearest, ties away, then clip
    assign w_rnd = {r_rem, 1'b0} >= {1'b0, r_dd};
    assign w_qr  = {1'b0, r_q} + {32'b0, w_rnd};
    assign w_lim = r_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign w_sat = w_qr > w_lim;
    assign w_val = w_sat ? w_lim : w_qr;
    assign w_out = r_neg ? (33'd0 - w_val) : w_val;

    // Control: start, iterate, finalize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {16'b0, w_mn[63:16]};
            r_nb  <= {w_mn[15:0], 16'b0};
            r_dd  <= w_dd;
            r_neg <= w_neg;
            r_cnt <= 5'd31;
            if (w_ovf) begin
                r_res.sat   <= 1'b1;
                r_res.value <= w_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? 64'(w_rem2 - {1'b0, r_dd}) : w_rem2[63:0];
            r_q   <= {r_q[30:0], w_ge};
            r_nb  <= {r_nb[30:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end else if (r_fin) begin
            r_res.sat   <= w_sat;
            r_res.value <= signed'(w_out[31:0]);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> design/mi4_checker.sv
// Port-level checks for matrix_inverse_4x4_core, attached by bind.
// Depends only on the core's ports.
`timescale 1ns / 1ps
`default_nettype none

module mi4_checker #(
    parameter int MATRIX_DIM = 4
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire signed [31:0] i_element_value,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [31:0] o_inverse_value,
    input wire [1:0]         o_out_row,
    input wire [1:0]         o_out_col,
    input wire signed [31:0] o_det_value,
    input wire               o_singular,
    input wire               o_saturated,
    input wire               o_last
);

    localparam logic [1:0] LASTIDX = 2'(MATRIX_DIM - 1);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // Drive zero values for a singular matrix
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_inverse_value == 32'sd0)
        else $error("singular result carries a nonzero value");

    // Flag last only on the final row and column
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (o_out_row == LASTIDX) && (o_out_col == LASTIDX))
        else $error("last flag on a wrong position");

    // Start new results only from the compute phase
    a_out_from_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item issued while loading");

endmodule

bind matrix_inverse_4x4_core mi4_checker #(.MATRIX_DIM(MATRIX_DIM)) u_mi4_checker (.*);

`default_nettype wire
